// File: design/tcsb_pkg.sv
// shared constants and types for the three-channel settling baseline core
// no dependencies; imported by every design module
package tcsb_pkg;

  localparam int WINDOW   = 3;
  localparam int NCH      = 3;
  localparam int SAMPLE_W = 16;
  localparam int TOL_W    = 8;
  localparam int SUM_W    = $clog2(WINDOW * (2 ** SAMPLE_W - 1) + 1);
  localparam int PTR_W    = $clog2(WINDOW);

  // reciprocal of the window length, exact floor for every reachable sum
  localparam int DIV_SHIFT = SUM_W + PTR_W;
  localparam int PROD_W    = SUM_W + DIV_SHIFT;
  localparam logic [DIV_SHIFT-1:0] RECIP =
    DIV_SHIFT'(((64'd1 << DIV_SHIFT) + 64'(WINDOW - 1)) / 64'(WINDOW));

  localparam int IN_TDATA_W  = ((NCH * SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_BITS    = NCH + 1 + NCH * SAMPLE_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(15);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(WINDOW - 1);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SUM_W-1:0]    sum_t;

  typedef struct packed {
    logic             take;
    logic             restart;
    logic [PTR_W-1:0] slot;
  } lane_ctl_t;

  typedef struct packed {
    logic    stable;
    sample_t baseline;
  } lane_res_t;

endpackage

// File: design/tcsb_lane.sv
// one channel lane: window ring, running sum, registered sum and sample,
// then average and tolerance check; uses tcsb_pkg
module tcsb_lane import tcsb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  lane_ctl_t        ctl,
  input  sample_t          sample,
  input  logic [TOL_W-1:0] tolerance,
  output lane_res_t        res
);

  sample_t             ring [WINDOW];
  sum_t                sum;
  sum_t                sum_next;
  sum_t                sum_q;
  sample_t             sample_q;
  logic [PROD_W-1:0]   prod;
  sum_t                quot;
  sample_t             avg;
  sample_t             diff;

  always_comb begin
    sum_t base;
    sum_t old;
    base     = ctl.restart ? '0 : sum;
    old      = ctl.restart ? '0 : SUM_W'(ring[ctl.slot]);
    sum_next = base + SUM_W'(sample) - old;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        ring[i] <= '0;
      end
    end else if (ctl.take) begin
      sum <= sum_next;
      for (int i = 0; i < WINDOW; i++) begin
        if (PTR_W'(i) == ctl.slot) begin
          ring[i] <= sample;
        end else if (ctl.restart) begin
          ring[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      sum_q    <= sum_next;
      sample_q <= sample;
    end
  end

  // divide by the window length through a reciprocal multiply
  assign prod = PROD_W'(sum_q) * PROD_W'(RECIP);
  assign quot = prod[PROD_W-1:DIV_SHIFT];
  assign avg  = quot[SAMPLE_W-1:0];
  assign diff = (avg >= sample_q) ? (avg - sample_q) : (sample_q - avg);

  assign res.baseline = avg;
  assign res.stable   = (diff < SAMPLE_W'(tolerance));

endmodule

// File: design/tcsb_merge.sv
// merge stage: combines the lane flags and baselines into the output register
// uses tcsb_pkg
module tcsb_merge import tcsb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic                   valid_in,
  input  lane_res_t              res [NCH],
  output logic                   valid,
  output logic [OUT_TDATA_W-1:0] data
);

  logic [OUT_TDATA_W-1:0] data_next;

  always_comb begin
    logic all_ok;
    all_ok    = 1'b1;
    data_next = '0;
    for (int i = 0; i < NCH; i++) begin
      data_next[i] = res[i].stable;
      all_ok       = all_ok & res[i].stable;
      data_next[NCH + 1 + i * SAMPLE_W +: SAMPLE_W] = res[i].baseline;
    end
    data_next[NCH] = all_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load && valid_in) begin
      data <= data_next;
    end
  end

endmodule

// File: design/three_channel_settling_baseline_core.sv
// three-channel settling detector with moving-average baselines, top level
// instantiates tcsb_lane and tcsb_merge; uses tcsb_pkg
//
// Takes one request per clock while s_axis_tready is high, each with three
// 16-bit samples and a restart flag. A taken request is registered in the lane
// sum and sample stage, then via the average and tolerance check into the
// output register, one item per cycle unless the output stalls. The rate is
// set by the per-channel running-sum update, which closes on itself. Baselines
// are floor(sum / 3) over the last three samples, empty slots zero after reset
// or restart. Tolerance resets to 15; the user must write it through
// cfg_wen/cfg_wdata only while the block is idle; the block won't enforce it.
module three_channel_settling_baseline_core import tcsb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [TOL_W-1:0]       cfg_wdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // sample_a, sample_b, sample_c
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // restart
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // stable_a, stable_b, stable_c, all_stable, baseline_a, baseline_b,
  // baseline_c, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [TOL_W-1:0] tolerance;
  logic [PTR_W-1:0] ptr;
  logic [PTR_W-1:0] slot;
  logic             stage_valid;
  logic             adv_out;
  logic             adv_stage;
  logic             take;
  lane_ctl_t        ctl;
  lane_res_t        res [NCH];

  assign adv_out       = !m_axis_tvalid || m_axis_tready;
  assign adv_stage     = !stage_valid || adv_out;
  assign s_axis_tready = adv_stage;
  assign take          = s_axis_tvalid && adv_stage;

  assign slot        = s_axis_tuser ? '0 : ptr;
  assign ctl.take    = take;
  assign ctl.restart = s_axis_tuser;
  assign ctl.slot    = slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg_wen) begin
      tolerance <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr         <= '0;
      stage_valid <= 1'b0;
    end else begin
      if (take) begin
        ptr <= (slot == LAST_SLOT) ? '0 : slot + PTR_W'(1);
      end
      if (adv_stage) begin
        stage_valid <= s_axis_tvalid;
      end
    end
  end

  for (genvar g = 0; g < NCH; g++) begin : g_lane
    tcsb_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .sample    (s_axis_tdata[g * SAMPLE_W +: SAMPLE_W]),
      .tolerance (tolerance),
      .res       (res[g])
    );
  end

  tcsb_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (adv_out),
    .valid_in (stage_valid),
    .res      (res),
    .valid    (m_axis_tvalid),
    .data     (m_axis_tdata)
  );

endmodule

// File: design/tcsb_checker.sv
// port-level checks for the three-channel settling baseline core, with bind
// uses tcsb_pkg
module tcsb_checker import tcsb_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result present after reset");

  // all-stable flag agrees with the per-channel flags
  a_all_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[NCH] == (&m_axis_tdata[NCH-1:0]))
    else $error("all_stable mismatch");

  // a ready sink never blocks the source
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input blocked while output ready");

endmodule

bind three_channel_settling_baseline_core tcsb_checker u_tcsb_checker (.*);
